### src/klsa_pkg.sv
// Shared types, constants and codes for the keyed light slot allocator.
`default_nettype none

package klsa_pkg;

    localparam int LIGHTS     = 32;
    localparam int IDX_W      = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;

    localparam int OP_W       = 2;
    localparam int KEY_W      = 16;
    localparam int TIME_W     = 32;
    localparam int ELAP_W     = 16;
    localparam int POS_W      = 24;
    localparam int SLOT_W     = 5;
    localparam int RAD_W      = 16;
    localparam int DEC_W      = 16;
    localparam int HOW_W      = 2;

    localparam int DIFF_W     = POS_W + 1;
    localparam int SQ_W       = 2 * POS_W;
    localparam int DIST_W     = SQ_W + 2;
    localparam int PROD_W     = ELAP_W + DEC_W;
    localparam int LOSS_SHIFT = 10;
    localparam int LOSS_W     = PROD_W - LOSS_SHIFT;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_DECAY = 2'd2;

    localparam logic [HOW_W-1:0] HOW_KEY      = 2'd0;
    localparam logic [HOW_W-1:0] HOW_EXPIRED  = 2'd1;
    localparam logic [HOW_W-1:0] HOW_FARTHEST = 2'd2;
    localparam logic [HOW_W-1:0] HOW_NONE     = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIGHTS - 1);

    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic [TIME_W-1:0]        expiry;
        logic [RAD_W-1:0]         radius;
        logic [DEC_W-1:0]         decay;
        logic signed [POS_W-1:0]  ox;
        logic signed [POS_W-1:0]  oy;
        logic signed [POS_W-1:0]  oz;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        t_entry            wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    typedef struct packed {
        logic                     vld;
        logic [IDX_W-1:0]         idx;
        logic signed [POS_W-1:0]  ox;
        logic signed [POS_W-1:0]  oy;
        logic signed [POS_W-1:0]  oz;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
    } t_dist_req;

    typedef struct packed {
        logic               vld;
        logic [IDX_W-1:0]   idx;
        logic [DIST_W-1:0]  sq_dist;
    } t_dist_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_WREAD,
        ST_WDATA,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

### src/keyed_light_slot_allocator_unit.sv
// Top level of the keyed light slot allocator.
//
//  channel   direction  handshake           payload
//  request   in         i_valid / o_stall   i_opcode .. i_decay_rate
//  result    out        o_valid / i_stall   o_chosen_slot, o_how_chosen
//
// One request at a time. Allocate: a scan over all LIGHTS slots, a drain of the
// distance pipeline, commit, result and idle. Decay: scan, a drain for the
// trailing write-back, result and idle. Write: table read, data write, result
// and idle; an unused opcode goes to result and idle. Reset empties the table at
// once (valid bits). A stalled result is held in the output register; the next
// request is taken while it waits.
`default_nettype none

module keyed_light_slot_allocator_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [klsa_pkg::OP_W-1:0]           i_opcode,
    input  wire logic [klsa_pkg::KEY_W-1:0]          i_light_key,
    input  wire logic [klsa_pkg::TIME_W-1:0]         i_now_time,
    input  wire logic [klsa_pkg::ELAP_W-1:0]         i_elapsed_time,
    input  wire logic signed [klsa_pkg::POS_W-1:0]   i_pos_x,
    input  wire logic signed [klsa_pkg::POS_W-1:0]   i_pos_y,
    input  wire logic signed [klsa_pkg::POS_W-1:0]   i_pos_z,
    input  wire logic [klsa_pkg::SLOT_W-1:0]         i_slot_index,
    input  wire logic [klsa_pkg::RAD_W-1:0]          i_new_radius,
    input  wire logic [klsa_pkg::TIME_W-1:0]         i_expiry_time,
    input  wire logic [klsa_pkg::DEC_W-1:0]          i_decay_rate,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [klsa_pkg::SLOT_W-1:0]              o_chosen_slot,
    output logic [klsa_pkg::HOW_W-1:0]               o_how_chosen
);

    klsa_pkg::t_mem_req   w_mem_req;
    klsa_pkg::t_entry     w_rdata;
    klsa_pkg::t_dist_req  w_dist_req;
    klsa_pkg::t_dist_rsp  w_dist_rsp;

    klsa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_light_key    (i_light_key),
        .i_now_time     (i_now_time),
        .i_elapsed_time (i_elapsed_time),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_slot_index   (i_slot_index),
        .i_new_radius   (i_new_radius),
        .i_expiry_time  (i_expiry_time),
        .i_decay_rate   (i_decay_rate),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_chosen_slot  (o_chosen_slot),
        .o_how_chosen   (o_how_chosen),
        .o_mem_req      (w_mem_req),
        .i_rdata        (w_rdata),
        .o_dist_req     (w_dist_req),
        .i_dist_rsp     (w_dist_rsp)
    );

    klsa_slot_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    klsa_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dist_req),
        .o_rsp   (w_dist_rsp)
    );

    a_no_rw_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_req.we && w_mem_req.re) |-> (w_mem_req.waddr != w_mem_req.raddr))
        else $error("table read and write hit the same slot");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted while busy");

    a_dist_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dist_rsp.vld |-> o_stall)
        else $error("distance result outside an allocate scan");

    a_alloc_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_how_chosen == klsa_pkg::HOW_NONE)
                     || (32'(o_chosen_slot) < 32'(klsa_pkg::LIGHTS))))
        else $error("allocated slot beyond table");

endmodule

`default_nettype wire

### src/klsa_slot_mem.sv
// Slot table memory: one write port, one registered read port, reset valid bits.
`default_nettype none

module klsa_slot_mem (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire klsa_pkg::t_mem_req i_req,
    output klsa_pkg::t_entry        o_rdata
);

    klsa_pkg::t_entry               r_mem [klsa_pkg::LIGHTS];
    logic [klsa_pkg::LIGHTS-1:0]    r_valid;
    klsa_pkg::t_entry               r_rdata;
    logic                           r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rvalid <= r_valid[i_req.raddr];
            end
        end
    end

    // never-written slots read as the cleared entry
    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

`default_nettype wire

### src/klsa_dist.sv
// Three-stage squared distance pipeline between a slot origin and the viewer.
`default_nettype none

module klsa_dist (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire klsa_pkg::t_dist_req i_req,
    output klsa_pkg::t_dist_rsp      o_rsp
);

    logic                                   r_s1_vld, r_s2_vld, r_s3_vld;
    logic [klsa_pkg::IDX_W-1:0]             r_s1_idx, r_s2_idx, r_s3_idx;
    logic signed [klsa_pkg::DIFF_W-1:0]     r_dx, r_dy, r_dz;
    logic [klsa_pkg::SQ_W-1:0]              r_qx, r_qy, r_qz;
    logic [klsa_pkg::DIST_W-1:0]            r_sum;
    logic signed [2*klsa_pkg::DIFF_W-1:0]   n_qx, n_qy, n_qz;

    assign n_qx = r_dx * r_dx;
    assign n_qy = r_dy * r_dy;
    assign n_qz = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_req.vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= i_req.idx;
        r_s2_idx <= r_s1_idx;
        r_s3_idx <= r_s2_idx;
        r_dx <= $signed({i_req.ox[klsa_pkg::POS_W-1], i_req.ox})
              - $signed({i_req.px[klsa_pkg::POS_W-1], i_req.px});
        r_dy <= $signed({i_req.oy[klsa_pkg::POS_W-1], i_req.oy})
              - $signed({i_req.py[klsa_pkg::POS_W-1], i_req.py});
        r_dz <= $signed({i_req.oz[klsa_pkg::POS_W-1], i_req.oz})
              - $signed({i_req.pz[klsa_pkg::POS_W-1], i_req.pz});
        r_qx <= n_qx[klsa_pkg::SQ_W-1:0];
        r_qy <= n_qy[klsa_pkg::SQ_W-1:0];
        r_qz <= n_qz[klsa_pkg::SQ_W-1:0];
        r_sum <= klsa_pkg::DIST_W'(r_qx) + klsa_pkg::DIST_W'(r_qy)
               + klsa_pkg::DIST_W'(r_qz);
    end

    assign o_rsp = '{vld: r_s3_vld, idx: r_s3_idx, sq_dist: r_sum};

endmodule

`default_nettype wire

### src/klsa_ctrl.sv
// Sequencer: request capture, table scan, decay read-modify-write and result register.
`default_nettype none

module klsa_ctrl (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [klsa_pkg::OP_W-1:0]           i_opcode,
    input  wire logic [klsa_pkg::KEY_W-1:0]          i_light_key,
    input  wire logic [klsa_pkg::TIME_W-1:0]         i_now_time,
    input  wire logic [klsa_pkg::ELAP_W-1:0]         i_elapsed_time,
    input  wire logic signed [klsa_pkg::POS_W-1:0]   i_pos_x,
    input  wire logic signed [klsa_pkg::POS_W-1:0]   i_pos_y,
    input  wire logic signed [klsa_pkg::POS_W-1:0]   i_pos_z,
    input  wire logic [klsa_pkg::SLOT_W-1:0]         i_slot_index,
    input  wire logic [klsa_pkg::RAD_W-1:0]          i_new_radius,
    input  wire logic [klsa_pkg::TIME_W-1:0]         i_expiry_time,
    input  wire logic [klsa_pkg::DEC_W-1:0]          i_decay_rate,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [klsa_pkg::SLOT_W-1:0]              o_chosen_slot,
    output logic [klsa_pkg::HOW_W-1:0]               o_how_chosen,
    output klsa_pkg::t_mem_req                       o_mem_req,
    input  wire klsa_pkg::t_entry                    i_rdata,
    output klsa_pkg::t_dist_req                      o_dist_req,
    input  wire klsa_pkg::t_dist_rsp                 i_dist_rsp
);

    klsa_pkg::t_state                   r_state, n_state;

    logic [klsa_pkg::OP_W-1:0]          r_op;
    logic [klsa_pkg::KEY_W-1:0]         r_key;
    logic [klsa_pkg::TIME_W-1:0]        r_now;
    logic [klsa_pkg::ELAP_W-1:0]        r_elapsed;
    logic signed [klsa_pkg::POS_W-1:0]  r_px, r_py, r_pz;
    logic [klsa_pkg::SLOT_W-1:0]        r_idx;
    logic [klsa_pkg::RAD_W-1:0]         r_radius;
    logic [klsa_pkg::TIME_W-1:0]        r_expiry;
    logic [klsa_pkg::DEC_W-1:0]         r_decay;

    logic [klsa_pkg::IDX_W-1:0]         r_addr;
    logic                               r_rd_vld;
    logic [klsa_pkg::IDX_W-1:0]         r_rd_idx;

    logic                               r_key_hit, r_exp_hit;
    logic [klsa_pkg::IDX_W-1:0]         r_key_idx, r_exp_idx, r_best_idx;
    logic [klsa_pkg::DIST_W-1:0]        r_best;

    logic                               r_dc_vld, r_dc_live;
    logic [klsa_pkg::IDX_W-1:0]         r_dc_idx;
    klsa_pkg::t_entry                   r_dc_ent;
    logic [klsa_pkg::PROD_W-1:0]        r_dc_prod;

    logic [klsa_pkg::SLOT_W-1:0]        r_res_slot, r_out_slot;
    logic [klsa_pkg::HOW_W-1:0]         r_res_how, r_out_how;
    logic                               r_out_vld;

    logic                               w_accept, w_load_out, w_idx_ok, w_drain_done;
    logic [klsa_pkg::IDX_W-1:0]         w_pick_idx;
    logic [klsa_pkg::HOW_W-1:0]         w_pick_how;
    logic [klsa_pkg::LOSS_W-1:0]        w_loss;
    logic [klsa_pkg::RAD_W-1:0]         w_dc_radius;
    klsa_pkg::t_mem_req                 n_req;

    assign w_accept = i_valid && !o_stall;
    assign w_idx_ok = 32'(r_idx) < 32'(klsa_pkg::LIGHTS);

    assign w_drain_done = (r_op == klsa_pkg::OP_ALLOC)
                        ? (i_dist_rsp.vld && i_dist_rsp.idx == klsa_pkg::LAST_IDX)
                        : (r_dc_vld && r_dc_idx == klsa_pkg::LAST_IDX);

    assign w_pick_idx = r_key_hit ? r_key_idx : (r_exp_hit ? r_exp_idx : r_best_idx);
    assign w_pick_how = r_key_hit ? klsa_pkg::HOW_KEY
                      : (r_exp_hit ? klsa_pkg::HOW_EXPIRED : klsa_pkg::HOW_FARTHEST);

    assign w_loss      = r_dc_prod[klsa_pkg::PROD_W-1:klsa_pkg::LOSS_SHIFT];
    assign w_dc_radius = (w_loss >= klsa_pkg::LOSS_W'(r_dc_ent.radius))
                       ? '0 : r_dc_ent.radius - w_loss[klsa_pkg::RAD_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            klsa_pkg::ST_IDLE: begin
                if (i_valid) begin
                    case (i_opcode) inside
                        klsa_pkg::OP_ALLOC, klsa_pkg::OP_DECAY: n_state = klsa_pkg::ST_SCAN;
                        klsa_pkg::OP_WRITE:                     n_state = klsa_pkg::ST_WREAD;
                        default:                                n_state = klsa_pkg::ST_RESP;
                    endcase
                end
            end
            klsa_pkg::ST_SCAN: begin
                if (r_addr == klsa_pkg::LAST_IDX) begin
                    n_state = klsa_pkg::ST_DRAIN;
                end
            end
            klsa_pkg::ST_DRAIN: begin
                if (w_drain_done) begin
                    n_state = (r_op == klsa_pkg::OP_ALLOC) ? klsa_pkg::ST_COMMIT
                                                           : klsa_pkg::ST_RESP;
                end
            end
            klsa_pkg::ST_COMMIT: n_state = klsa_pkg::ST_RESP;
            klsa_pkg::ST_WREAD:  n_state = klsa_pkg::ST_WDATA;
            klsa_pkg::ST_WDATA:  n_state = klsa_pkg::ST_RESP;
            klsa_pkg::ST_RESP: begin
                if (!r_out_vld || !i_stall) begin
                    n_state = klsa_pkg::ST_IDLE;
                end
            end
            default: n_state = klsa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_req      = '0;
        o_stall    = 1'b1;
        w_load_out = 1'b0;
        unique case (r_state)
            klsa_pkg::ST_IDLE: o_stall = 1'b0;
            klsa_pkg::ST_SCAN: begin
                n_req.re    = 1'b1;
                n_req.raddr = r_addr;
            end
            klsa_pkg::ST_COMMIT: begin
                n_req.we        = 1'b1;
                n_req.waddr     = w_pick_idx;
                n_req.wdata.key = r_key;
            end
            klsa_pkg::ST_WREAD: begin
                n_req.re    = 1'b1;
                n_req.raddr = klsa_pkg::IDX_W'(r_idx);
            end
            klsa_pkg::ST_WDATA: begin
                n_req.we    = w_idx_ok;
                n_req.waddr = klsa_pkg::IDX_W'(r_idx);
                n_req.wdata = '{key: i_rdata.key, expiry: r_expiry, radius: r_radius,
                                decay: r_decay, ox: r_px, oy: r_py, oz: r_pz};
            end
            klsa_pkg::ST_RESP: w_load_out = !r_out_vld || !i_stall;
            default: ;
        endcase
        // decay write-back follows its read through the table read register and the r_dc_ registers
        if (r_dc_vld && r_dc_live) begin
            n_req.we           = 1'b1;
            n_req.waddr        = r_dc_idx;
            n_req.wdata        = r_dc_ent;
            n_req.wdata.radius = w_dc_radius;
        end
    end

    assign o_mem_req  = n_req;
    assign o_dist_req = '{vld: r_rd_vld && (r_op == klsa_pkg::OP_ALLOC), idx: r_rd_idx,
                          ox: i_rdata.ox, oy: i_rdata.oy, oz: i_rdata.oz,
                          px: r_px, py: r_py, pz: r_pz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= klsa_pkg::ST_IDLE;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_key_hit <= 1'b0;
            r_exp_hit <= 1'b0;
            r_best    <= '0;
            r_best_idx <= '0;
            r_dc_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == klsa_pkg::ST_SCAN);
            r_dc_vld <= r_rd_vld && (r_op == klsa_pkg::OP_DECAY);

            if (w_accept) begin
                r_addr <= '0;
            end else if (r_state == klsa_pkg::ST_SCAN) begin
                r_addr <= r_addr + klsa_pkg::IDX_W'(1);
            end

            if (w_accept) begin
                r_key_hit  <= 1'b0;
                r_exp_hit  <= 1'b0;
                r_best     <= '0;
                r_best_idx <= '0;
            end else begin
                if (r_rd_vld && (r_op == klsa_pkg::OP_ALLOC)) begin
                    if (!r_key_hit && (r_key != '0) && (i_rdata.key == r_key)) begin
                        r_key_hit <= 1'b1;
                    end
                    if (!r_exp_hit && (i_rdata.expiry < r_now)) begin
                        r_exp_hit <= 1'b1;
                    end
                end
                // first strict maximum wins
                if (i_dist_rsp.vld && (i_dist_rsp.sq_dist > r_best)) begin
                    r_best     <= i_dist_rsp.sq_dist;
                    r_best_idx <= i_dist_rsp.idx;
                end
            end

            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_opcode;
            r_key     <= i_light_key;
            r_now     <= i_now_time;
            r_elapsed <= i_elapsed_time;
            r_px      <= i_pos_x;
            r_py      <= i_pos_y;
            r_pz      <= i_pos_z;
            r_idx     <= i_slot_index;
            r_radius  <= i_new_radius;
            r_expiry  <= i_expiry_time;
            r_decay   <= i_decay_rate;
            r_res_slot <= (i_opcode == klsa_pkg::OP_WRITE) ? i_slot_index : '0;
            r_res_how  <= klsa_pkg::HOW_NONE;
        end else if (r_state == klsa_pkg::ST_COMMIT) begin
            r_res_slot <= klsa_pkg::SLOT_W'(w_pick_idx);
            r_res_how  <= w_pick_how;
        end

        r_rd_idx <= r_addr;
        if (r_rd_vld && (r_op == klsa_pkg::OP_ALLOC)) begin
            if (!r_key_hit && (r_key != '0) && (i_rdata.key == r_key)) begin
                r_key_idx <= r_rd_idx;
            end
            if (!r_exp_hit && (i_rdata.expiry < r_now)) begin
                r_exp_idx <= r_rd_idx;
            end
        end

        r_dc_idx  <= r_rd_idx;
        r_dc_ent  <= i_rdata;
        r_dc_live <= !(i_rdata.expiry < r_now) && (i_rdata.radius != '0);
        r_dc_prod <= klsa_pkg::PROD_W'(r_elapsed) * klsa_pkg::PROD_W'(i_rdata.decay);

        if (w_load_out) begin
            r_out_slot <= r_res_slot;
            r_out_how  <= r_res_how;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_chosen_slot = r_out_slot;
    assign o_how_chosen  = r_out_how;

endmodule

`default_nettype wire
